>>> rtl/core/twtd_pkg.sv
// shared types, codes and sizes for the tree wave termination detector
// no dependencies; imported by every module of the block
package twtd_pkg;

  localparam int RANK_W  = 10;
  localparam int COUNT_W = 11;
  localparam int TOTAL_W = 64;
  localparam int CMD_W   = 3;
  // run length and child count field, wide enough for an arity of up to 7
  localparam int RUN_W   = 3;

  localparam int DEF_ARITY       = 4;
  localparam int DEF_MAX_RANKS   = 1024;
  localparam int DEF_COUNT_WIDTH = 64;

  typedef enum logic [CMD_W-1:0] {
    CMD_START = 3'd0,
    CMD_SEND  = 3'd1,
    CMD_RECV  = 3'd2,
    CMD_CTRL  = 3'd3,
    CMD_RESP  = 3'd4,
    CMD_TERM  = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_CTRL = 2'd0,
    KIND_RESP = 2'd1,
    KIND_TERM = 2'd2,
    KIND_DONE = 2'd3
  } kind_t;

  typedef enum logic [0:0] {
    REG_NODE_RANK  = 1'b0,
    REG_RANK_COUNT = 1'b1
  } cfg_reg_t;

  // tree position of this node
  typedef struct packed {
    logic              root;
    logic              single;
    logic [RANK_W-1:0] rank;
    logic [RANK_W-1:0] first;
    logic [RUN_W-1:0]  kids;
    logic [RANK_W-1:0] parent;
  } topo_t;

  // first result of a run plus what follows it
  typedef struct packed {
    logic               valid;
    kind_t              kind;
    logic [RANK_W-1:0]  dest;
    logic [TOTAL_W-1:0] sent;
    logic [TOTAL_W-1:0] recv;
    logic               last;
    logic [RUN_W-1:0]   rem;
    logic               tail;
    logic [RANK_W-1:0]  own;
  } desc_t;

endpackage

>>> rtl/core/twtd_topo.sv
// tree position decode: first child, child count and parent from rank and rank count
// depends on twtd_pkg
module twtd_topo #(
  parameter int ARITY     = twtd_pkg::DEF_ARITY,
  parameter int MAX_RANKS = twtd_pkg::DEF_MAX_RANKS
) (
  input  logic [twtd_pkg::RANK_W-1:0]  node_rank,
  input  logic [twtd_pkg::COUNT_W-1:0] rank_count,
  output twtd_pkg::topo_t              topo
);
  import twtd_pkg::*;

  localparam int PEND_W    = $clog2(ARITY + 1);
  localparam int FIRST_W   = RANK_W + PEND_W;
  localparam int DIV_SHIFT = 13;
  localparam int DIV_MULT  = (2**DIV_SHIFT + ARITY - 1) / ARITY;
  localparam int PROD_W    = RANK_W + DIV_SHIFT + 1;

  logic [COUNT_W-1:0] n_eff;
  logic [FIRST_W-1:0] first_full;
  logic [FIRST_W-1:0] n_ext;
  logic [FIRST_W-1:0] diff;
  logic [RUN_W-1:0]   kids;
  logic [RANK_W-1:0]  rank_m1;
  logic [PROD_W-1:0]  prod;

  always_comb begin
    n_eff = rank_count;
    if (rank_count == '0) n_eff = COUNT_W'(1);
    if (32'(rank_count) > 32'(MAX_RANKS)) n_eff = COUNT_W'(MAX_RANKS);
  end

  assign first_full = FIRST_W'(FIRST_W'(node_rank) * FIRST_W'(ARITY)) + FIRST_W'(1);
  assign n_ext      = FIRST_W'(n_eff);
  assign diff       = (n_ext > first_full) ? (n_ext - first_full) : '0;
  assign kids       = (diff < FIRST_W'(ARITY)) ? RUN_W'(diff) : RUN_W'(ARITY);

  // divide by arity through a scaled reciprocal, exact for ten-bit ranks
  assign rank_m1 = node_rank - RANK_W'(1);
  assign prod    = PROD_W'(rank_m1) * PROD_W'(DIV_MULT);

  assign topo.root   = (node_rank == '0);
  assign topo.single = (n_eff == COUNT_W'(1));
  assign topo.rank   = node_rank;
  assign topo.first  = first_full[RANK_W-1:0];
  assign topo.kids   = kids;
  assign topo.parent = prod[DIV_SHIFT +: RANK_W];

endmodule

>>> rtl/core/twtd_core.sv
// input register, counters and wave state; turns one item into a result run descriptor
// depends on twtd_pkg
module twtd_core #(
  parameter int ARITY       = twtd_pkg::DEF_ARITY,
  parameter int COUNT_WIDTH = twtd_pkg::DEF_COUNT_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [twtd_pkg::CMD_W-1:0]   command,
  input  logic [twtd_pkg::TOTAL_W-1:0] child_sent,
  input  logic [twtd_pkg::TOTAL_W-1:0] child_recv,
  input  twtd_pkg::topo_t              topo,
  input  logic                         emit_free,
  output twtd_pkg::desc_t              desc
);
  import twtd_pkg::*;

  localparam int PEND_W = $clog2(ARITY + 1);
  localparam int CW     = COUNT_WIDTH;

  logic                 item_valid;
  logic [CMD_W-1:0]     cmd_q;
  logic [CW-1:0]        cs_q;
  logic [CW-1:0]        cr_q;

  logic [CW-1:0]        local_sent, local_sent_next;
  logic [CW-1:0]        local_recv, local_recv_next;
  logic [CW-1:0]        acc_sent, acc_sent_next;   // wave total plus local count
  logic [CW-1:0]        acc_recv, acc_recv_next;
  logic [CW-1:0]        prior_sent, prior_sent_next;
  logic [CW-1:0]        prior_recv, prior_recv_next;
  logic [PEND_W-1:0]    pending, pending_next;
  logic                 done, done_next;

  logic [CW-1:0]        sum_sent, sum_recv;
  logic [CW-1:0]        resp_sent, resp_recv;
  logic [PEND_W-1:0]    pend_dec;
  logic                 do_check, do_ctrl, do_term, do_resp;
  logic                 has_res;
  logic                 fire;
  logic                 match;

  assign fire     = item_valid && (!has_res || emit_free);
  assign in_ready = !item_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      cmd_q <= command;
      cs_q  <= child_sent[CW-1:0];
      cr_q  <= child_recv[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      local_sent <= '0;
      local_recv <= '0;
      acc_sent   <= '0;
      acc_recv   <= '0;
      prior_sent <= '0;
      prior_recv <= '0;
      pending    <= '0;
      done       <= 1'b0;
    end else if (fire) begin
      local_sent <= local_sent_next;
      local_recv <= local_recv_next;
      acc_sent   <= acc_sent_next;
      acc_recv   <= acc_recv_next;
      prior_sent <= prior_sent_next;
      prior_recv <= prior_recv_next;
      pending    <= pending_next;
      done       <= done_next;
    end
  end

  assign sum_sent = acc_sent + ((cmd_t'(cmd_q) == CMD_RESP) ? cs_q : '0);
  assign sum_recv = acc_recv + ((cmd_t'(cmd_q) == CMD_RESP) ? cr_q : '0);
  assign pend_dec = (pending != '0) ? pending - PEND_W'(1) : '0;
  assign match    = (sum_sent == sum_recv) && (prior_sent == prior_recv) &&
                    (sum_sent == prior_sent) && (sum_sent != '0);

  always_comb begin
    local_sent_next = local_sent;
    local_recv_next = local_recv;
    acc_sent_next   = acc_sent;
    acc_recv_next   = acc_recv;
    prior_sent_next = prior_sent;
    prior_recv_next = prior_recv;
    pending_next    = pending;
    done_next       = done;
    do_check        = 1'b0;
    do_ctrl         = 1'b0;
    do_term         = 1'b0;
    do_resp         = 1'b0;
    resp_sent       = sum_sent;
    resp_recv       = sum_recv;

    unique case (cmd_t'(cmd_q)) inside
      CMD_START, CMD_CTRL: begin
        if (topo.root) begin
          pending_next = PEND_W'(topo.kids);
          if (topo.single) do_check = 1'b1;
          else do_ctrl = 1'b1;
        end else if (cmd_t'(cmd_q) == CMD_CTRL) begin
          pending_next = PEND_W'(topo.kids);
          if (topo.kids != '0) begin
            do_ctrl = 1'b1;
          end else begin
            // leaf answers with its own counts, wave totals untouched
            do_resp   = 1'b1;
            resp_sent = local_sent;
            resp_recv = local_recv;
          end
        end
      end
      CMD_SEND: begin
        if (!done) begin
          local_sent_next = local_sent + CW'(1);
          acc_sent_next   = acc_sent + CW'(1);
        end
      end
      CMD_RECV: begin
        if (!done) begin
          local_recv_next = local_recv + CW'(1);
          acc_recv_next   = acc_recv + CW'(1);
        end
      end
      CMD_RESP: begin
        acc_sent_next = sum_sent;
        acc_recv_next = sum_recv;
        pending_next  = pend_dec;
        if (pend_dec == '0) do_check = 1'b1;
      end
      CMD_TERM: do_term = 1'b1;
      default: ;
    endcase

    if (do_check) begin
      acc_sent_next = local_sent;
      acc_recv_next = local_recv;
      if (topo.root) begin
        if (match) begin
          do_term = 1'b1;
          // the closing wave keeps its totals, the local counts stay on top
          acc_sent_next = sum_sent + local_sent;
          acc_recv_next = sum_recv + local_recv;
        end else begin
          prior_sent_next = sum_sent;
          prior_recv_next = sum_recv;
          if (!topo.single) begin
            pending_next = PEND_W'(topo.kids);
            do_ctrl      = 1'b1;
          end
        end
      end else begin
        do_resp      = 1'b1;
        pending_next = PEND_W'(topo.kids);
      end
    end

    if (do_term) done_next = 1'b1;
  end

  assign has_res = do_ctrl || do_term || do_resp;

  always_comb begin
    desc.valid = fire && has_res;
    desc.kind  = KIND_CTRL;
    desc.dest  = topo.first;
    desc.sent  = '0;
    desc.recv  = '0;
    desc.last  = (topo.kids == RUN_W'(1));
    desc.rem   = topo.kids - RUN_W'(1);
    desc.tail  = 1'b0;
    desc.own   = topo.rank;
    if (do_resp) begin
      desc.kind = KIND_RESP;
      desc.dest = topo.parent;
      desc.sent = TOTAL_W'(resp_sent);
      desc.recv = TOTAL_W'(resp_recv);
      desc.last = 1'b1;
      desc.rem  = '0;
    end else if (do_term) begin
      if (topo.kids != '0) begin
        desc.kind = KIND_TERM;
        desc.last = 1'b0;
        desc.tail = 1'b1;
      end else begin
        desc.kind = KIND_DONE;
        desc.dest = topo.rank;
        desc.last = 1'b1;
        desc.rem  = '0;
      end
    end
  end

  a_pending_range: assert property (@(posedge clk) disable iff (rst)
    32'(pending) <= ARITY)
    else $error("pending responses exceed arity");

  a_done_sticky: assert property (@(posedge clk) disable iff (rst)
    done |=> done)
    else $error("termination flag dropped");

  a_no_count_after_done: assert property (@(posedge clk) disable iff (rst)
    (fire && done && (cmd_t'(cmd_q) == CMD_SEND)) |=> $stable(local_sent))
    else $error("send counted after termination");

  a_ctrl_has_kids: assert property (@(posedge clk) disable iff (rst)
    (desc.valid && desc.kind == KIND_CTRL) |-> (topo.kids != '0))
    else $error("control run with no children");

endmodule

>>> rtl/core/twtd_emit.sv
// result serializer: output register that walks a run of child messages and its tail
// depends on twtd_pkg
module twtd_emit (
  input  logic                          clk,
  input  logic                          rst,
  input  twtd_pkg::desc_t               desc,
  output logic                          emit_free,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    message_kind,
  output logic [twtd_pkg::RANK_W-1:0]   dest_rank,
  output logic [twtd_pkg::TOTAL_W-1:0]  total_sent,
  output logic [twtd_pkg::TOTAL_W-1:0]  total_recv,
  output logic                          last
);
  import twtd_pkg::*;

  logic [RUN_W-1:0] rem;
  logic             tail;
  logic [RANK_W-1:0] own;
  logic             step;

  assign emit_free = !out_valid || (out_ready && last);
  assign step      = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      rem       <= '0;
      tail      <= 1'b0;
    end else if (desc.valid) begin
      out_valid    <= 1'b1;
      message_kind <= desc.kind;
      dest_rank    <= desc.dest;
      total_sent   <= desc.sent;
      total_recv   <= desc.recv;
      last         <= desc.last;
      rem          <= desc.rem;
      tail         <= desc.tail;
      own          <= desc.own;
    end else if (step) begin
      if (last) begin
        out_valid <= 1'b0;
      end else if (rem != '0) begin
        // next child in the run
        dest_rank <= dest_rank + RANK_W'(1);
        rem       <= rem - RUN_W'(1);
        last      <= (rem == RUN_W'(1)) && !tail;
      end else begin
        // local termination notice closes the run
        message_kind <= KIND_DONE;
        dest_rank    <= own;
        total_sent   <= '0;
        total_recv   <= '0;
        last         <= 1'b1;
        tail         <= 1'b0;
      end
    end
  end

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    desc.valid |-> emit_free)
    else $error("run loaded over a pending beat");

  a_more_to_come: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last) |-> ((rem != '0) || tail))
    else $error("non-final beat with nothing after it");

  a_tail_pending: assert property (@(posedge clk) disable iff (rst)
    tail |-> (out_valid && !last))
    else $error("tail pending on a final beat");

endmodule

>>> rtl/core/tree_wave_termination_detector_unit.sv
// top level of one tree node of the four-counter wave termination detector
// depends on twtd_pkg, twtd_topo, twtd_core, twtd_emit
//
//   channel | signals                                              | role
//   --------+------------------------------------------------------+---------------------
//   in      | in_valid in_ready command child_sent child_recv      | one command per beat
//   out     | out_valid out_ready message_kind dest_rank           | one message per beat
//           | total_sent total_recv last                           |
//   cfg     | cfg_write cfg_index cfg_data                         | register write, no wait
//
// an item passes from the input register into the output register, from which its first
// beat leaves; counting items run at one per cycle while no item with results is waiting
// an item that makes results takes 1 to ARITY+1 output beats, one per cycle while out_ready
// is high; it waits in the input register until the prior run's last beat leaves
// synchronous reset clears all counters, the wave state and both valid flags;
// node_rank resets to 0 and rank_count to 1
// a stalled output keeps its beat; counting items still pass, the next item with results
// waits in the input register
module tree_wave_termination_detector_unit #(
  parameter int ARITY       = twtd_pkg::DEF_ARITY,
  parameter int MAX_RANKS   = twtd_pkg::DEF_MAX_RANKS,
  parameter int COUNT_WIDTH = twtd_pkg::DEF_COUNT_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [0:0]                    cfg_index,
  input  logic [twtd_pkg::COUNT_W-1:0]  cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [twtd_pkg::CMD_W-1:0]    command,
  input  logic [twtd_pkg::TOTAL_W-1:0]  child_sent,
  input  logic [twtd_pkg::TOTAL_W-1:0]  child_recv,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    message_kind,
  output logic [twtd_pkg::RANK_W-1:0]   dest_rank,
  output logic [twtd_pkg::TOTAL_W-1:0]  total_sent,
  output logic [twtd_pkg::TOTAL_W-1:0]  total_recv,
  output logic                          last
);
  import twtd_pkg::*;

  logic [RANK_W-1:0]  node_rank;
  logic [COUNT_W-1:0] rank_count;
  topo_t              topo;
  desc_t              desc;
  logic               emit_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_rank  <= '0;
      rank_count <= COUNT_W'(1);
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_NODE_RANK:  node_rank  <= cfg_data[RANK_W-1:0];
        REG_RANK_COUNT: rank_count <= cfg_data;
      endcase
    end
  end

  twtd_topo #(
    .ARITY     (ARITY),
    .MAX_RANKS (MAX_RANKS)
  ) u_topo (
    .node_rank  (node_rank),
    .rank_count (rank_count),
    .topo       (topo)
  );

  twtd_core #(
    .ARITY       (ARITY),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .command    (command),
    .child_sent (child_sent),
    .child_recv (child_recv),
    .topo       (topo),
    .emit_free  (emit_free),
    .desc       (desc)
  );

  twtd_emit u_emit (
    .clk          (clk),
    .rst          (rst),
    .desc         (desc),
    .emit_free    (emit_free),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .message_kind (message_kind),
    .dest_rank    (dest_rank),
    .total_sent   (total_sent),
    .total_recv   (total_recv),
    .last         (last)
  );

endmodule

>>> tb/twtd_wave_checker.sv
`timescale 1ns / 1ps
// checker for one tree node of the wave termination detector: predicts the message beats
// of every accepted command and compares them, field by field, with the output channel
// depends on twtd_pkg
module twtd_wave_checker #(
  parameter int ARITY     = twtd_pkg::DEF_ARITY,
  parameter int MAX_RANKS = twtd_pkg::DEF_MAX_RANKS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [0:0]                   cfg_index,
  input  logic [twtd_pkg::COUNT_W-1:0] cfg_data,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic [twtd_pkg::CMD_W-1:0]   command,
  input  logic [twtd_pkg::TOTAL_W-1:0] child_sent,
  input  logic [twtd_pkg::TOTAL_W-1:0] child_recv,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [1:0]                   message_kind,
  input  logic [twtd_pkg::RANK_W-1:0]  dest_rank,
  input  logic [twtd_pkg::TOTAL_W-1:0] total_sent,
  input  logic [twtd_pkg::TOTAL_W-1:0] total_recv,
  input  logic                         last,
  output int                           errors,
  output int                           pending,
  output int                           beats,
  output int                           done_seen
);
  import twtd_pkg::*;

  typedef struct {
    kind_t              kind;
    logic [RANK_W-1:0]  dest;
    logic [TOTAL_W-1:0] sent;
    logic [TOTAL_W-1:0] recv;
    logic               last;
  } msg_t;

  msg_t msgs_due[$];

  logic [RANK_W-1:0]  my_rank;
  logic [COUNT_W-1:0] rank_total;
  logic [TOTAL_W-1:0] own_sent, own_recv;
  logic [TOTAL_W-1:0] gather_sent, gather_recv;
  logic [TOTAL_W-1:0] last_sent, last_recv;
  int unsigned        kids_left;
  logic               terminated;

  function automatic int unsigned ranks_live();
    int unsigned c;
    c = rank_total;
    if (c == 0) c = 1;
    if (c > MAX_RANKS) c = MAX_RANKS;
    return c;
  endfunction

  function automatic int unsigned kid_base();
    return int'(my_rank) * ARITY + 1;
  endfunction

  function automatic int unsigned kid_count();
    int unsigned n, f;
    n = ranks_live();
    f = kid_base();
    if (n <= f) return 0;
    return (n - f < ARITY) ? n - f : ARITY;
  endfunction

  function automatic int unsigned parent_rank();
    return (int'(my_rank) - 1) / ARITY;
  endfunction

  function automatic void emit(kind_t k, int unsigned dest, logic [TOTAL_W-1:0] s,
                               logic [TOTAL_W-1:0] r);
    msgs_due.push_back('{k, RANK_W'(dest), s, r, 1'b0});
  endfunction

  function automatic void fan_out(kind_t k);
    int unsigned f, n;
    f = kid_base();
    n = kid_count();
    for (int unsigned i = 0; i < n; i++) emit(k, f + i, '0, '0);
  endfunction

  function automatic void terminate_node();
    terminated = 1'b1;
    fan_out(KIND_TERM);
    emit(KIND_DONE, my_rank, '0, '0);
  endfunction

  // all responses in: the root judges the wave, other nodes report upward
  function automatic void close_wave();
    if (kids_left != 0) return;
    if (my_rank == 0) begin
      gather_sent = gather_sent + own_sent;
      gather_recv = gather_recv + own_recv;
      if (gather_sent == gather_recv && last_sent == last_recv &&
          gather_sent == last_sent && gather_sent != 0) begin
        terminate_node();
      end else begin
        last_sent   = gather_sent;
        last_recv   = gather_recv;
        gather_sent = '0;
        gather_recv = '0;
        // a single-rank root does not restart on its own
        if (ranks_live() != 1) begin
          kids_left = kid_count();
          fan_out(KIND_CTRL);
        end
      end
    end else begin
      emit(KIND_RESP, parent_rank(), gather_sent + own_sent, gather_recv + own_recv);
      gather_sent = '0;
      gather_recv = '0;
      kids_left   = kid_count();
    end
  endfunction

  function automatic void open_wave();
    if (my_rank != 0) return;
    kids_left = kid_count();
    fan_out(KIND_CTRL);
    if (ranks_live() == 1) close_wave();
  endfunction

  function automatic void apply_command(logic [CMD_W-1:0] op, logic [TOTAL_W-1:0] s,
                                        logic [TOTAL_W-1:0] r);
    int before_n;
    before_n = msgs_due.size();
    case (op)
      CMD_START: open_wave();
      CMD_SEND: if (!terminated) own_sent = own_sent + 1;
      CMD_RECV: if (!terminated) own_recv = own_recv + 1;
      CMD_CTRL: begin
        if (my_rank == 0) begin
          open_wave();
        end else begin
          kids_left = kid_count();
          if (kids_left > 0) fan_out(KIND_CTRL);
          else emit(KIND_RESP, parent_rank(), own_sent, own_recv);
        end
      end
      CMD_RESP: begin
        gather_sent = gather_sent + s;
        gather_recv = gather_recv + r;
        if (kids_left > 0) kids_left--;
        close_wave();
      end
      CMD_TERM: terminate_node();
      default: ;
    endcase
    if (msgs_due.size() > before_n) msgs_due[msgs_due.size()-1].last = 1'b1;
  endfunction

  function automatic void check_beat();
    msg_t want;
    beats++;
    if (message_kind == KIND_DONE) done_seen++;
    if (msgs_due.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("%t unexpected beat: kind %0d dest %0d sent %h recv %h last %b", $time,
                 message_kind, dest_rank, total_sent, total_recv, last);
      return;
    end
    want = msgs_due.pop_front();
    if (want.kind !== message_kind || want.dest !== dest_rank || want.sent !== total_sent ||
        want.recv !== total_recv || want.last !== last) begin
      errors++;
      if (errors <= 10) begin
        $display("%t beat mismatch, expected: kind %0d dest %0d sent %h recv %h last %b",
                 $time, want.kind, want.dest, want.sent, want.recv, want.last);
        $display("%t                  actual: kind %0d dest %0d sent %h recv %h last %b",
                 $time, message_kind, dest_rank, total_sent, total_recv, last);
      end
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      my_rank     = '0;
      rank_total  = COUNT_W'(1);
      own_sent    = '0;
      own_recv    = '0;
      gather_sent = '0;
      gather_recv = '0;
      last_sent   = '0;
      last_recv   = '0;
      kids_left   = 0;
      terminated  = 1'b0;
      msgs_due.delete();
      errors      = 0;
      beats       = 0;
      done_seen   = 0;
      pending     = 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_NODE_RANK:  my_rank = cfg_data[RANK_W-1:0];
          REG_RANK_COUNT: rank_total = cfg_data;
          default: ;
        endcase
      end
      // output first: a beat can never come from the command accepted on the same edge
      if (out_valid && out_ready) check_beat();
      if (in_valid && in_ready) apply_command(command, child_sent, child_recv);
      pending = msgs_due.size();
    end
  end

endmodule

>>> tb/tb_tree_wave_termination_detector_unit.sv
`timescale 1ns / 1ps
// top of the testbench for tree_wave_termination_detector_unit: clock, reset, command
// stimulus across several tree settings, output back-pressure and the final verdict
// depends on twtd_pkg, twtd_wave_checker and the block itself
module tb_tree_wave_termination_detector_unit;
  import twtd_pkg::*;

  localparam int ARITY       = DEF_ARITY;
  localparam int MAX_RANKS   = DEF_MAX_RANKS;
  localparam int STALL_LIMIT = 500;

  // command codes the block does not define
  localparam logic [CMD_W-1:0] CMD_RSVD_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSVD_HI = 3'd7;

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_write;
  logic [0:0]         cfg_index;
  logic [COUNT_W-1:0] cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic [CMD_W-1:0]   command;
  logic [TOTAL_W-1:0] child_sent;
  logic [TOTAL_W-1:0] child_recv;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         message_kind;
  logic [RANK_W-1:0]  dest_rank;
  logic [TOTAL_W-1:0] total_sent;
  logic [TOTAL_W-1:0] total_recv;
  logic               last;

  int errors, pending, beats, done_seen;
  int items_live = 0;
  int settings_used = 0;
  bit quiet = 1'b0;
  logic out_took = 1'b0;
  int sink_hold = 0;
  int sink_gap;
  logic [TOTAL_W-1:0] kid_sent [ARITY];
  logic [TOTAL_W-1:0] kid_recv [ARITY];
  int local_gap;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  tree_wave_termination_detector_unit #(
    .ARITY     (ARITY),
    .MAX_RANKS (MAX_RANKS)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .child_sent   (child_sent),
    .child_recv   (child_recv),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .message_kind (message_kind),
    .dest_rank    (dest_rank),
    .total_sent   (total_sent),
    .total_recv   (total_recv),
    .last         (last)
  );

  twtd_wave_checker #(
    .ARITY     (ARITY),
    .MAX_RANKS (MAX_RANKS)
  ) i_check (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .child_sent   (child_sent),
    .child_recv   (child_recv),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .message_kind (message_kind),
    .dest_rank    (dest_rank),
    .total_sent   (total_sent),
    .total_recv   (total_recv),
    .last         (last),
    .errors       (errors),
    .pending      (pending),
    .beats        (beats),
    .done_seen    (done_seen)
  );

  function automatic int gap_draw();
    return quiet ? 0 : $urandom_range(0, 10);
  endfunction

  function automatic logic [TOTAL_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // output side: a stall is drawn after every beat, plus random dips while idle
  always @(posedge clk) out_took <= out_valid && out_ready;

  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      sink_hold <= 0;
    end else if (out_took) begin
      sink_gap = gap_draw();
      out_ready <= (sink_gap == 0);
      sink_hold <= (sink_gap == 0) ? 0 : sink_gap - 1;
    end else if (sink_hold != 0) begin
      sink_hold <= sink_hold - 1;
    end else begin
      out_ready <= quiet || ($urandom_range(0, 3) != 0);
    end
  end

  // entered and left at a falling edge; valid drops only when a gap is drawn
  task automatic push_item(input logic [CMD_W-1:0] op, input logic [TOTAL_W-1:0] s,
                           input logic [TOTAL_W-1:0] r);
    int gap;
    gap = gap_draw();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    command    <= op;
    child_sent <= s;
    child_recv <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    if (op != CMD_RSVD_LO && op != CMD_RSVD_HI) items_live++;
  endtask

  task automatic push_op(input logic [CMD_W-1:0] op);
    push_item(op, rand64(), rand64());
  endtask

  // registers change only with nothing in flight; count-only commands leave no trace,
  // so the task waits further for the input register to drain
  task automatic set_config(input logic [RANK_W-1:0] rank, input logic [COUNT_W-1:0] count);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= REG_NODE_RANK;
    cfg_data  <= COUNT_W'(rank);
    @(negedge clk);
    cfg_index <= REG_RANK_COUNT;
    cfg_data  <= count;
    @(negedge clk);
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  // rounds of wave traffic: opener, local counting, at most one response per child, some noise
  task automatic run_phase(input logic [RANK_W-1:0] rank, input logic [COUNT_W-1:0] count,
                           input int n, input bit with_term);
    int unsigned live, first, kids;
    int stop_at, d;
    bit calm;
    logic [CMD_W-1:0] noise_op;
    set_config(rank, count);
    live  = (count == 0) ? 1 : ((count > MAX_RANKS) ? MAX_RANKS : count);
    first = int'(rank) * ARITY + 1;
    kids  = (live > first) ? ((live - first < ARITY) ? live - first : ARITY) : 0;
    for (int k = 0; k < ARITY; k++) begin
      kid_sent[k] = rand64();
      kid_recv[k] = kid_sent[k];
    end
    local_gap = 0;
    stop_at = items_live + n;
    while (items_live < stop_at) begin
      quiet = ($urandom_range(0, 4) == 0);
      // calm rounds skip the local counting and the child total changes, so two in a row can end the detection
      calm = ($urandom_range(0, 2) == 0);
      if (rank == 0) begin
        if (kids == 0 || $urandom_range(0, 2) == 0)
          push_op(($urandom_range(0, 3) == 0) ? CMD_CTRL : CMD_START);
      end else if ($urandom_range(0, 7) != 0) begin
        push_op(CMD_CTRL);
      end
      if (!calm) begin
        repeat ($urandom_range(0, 3)) begin
          if ($urandom_range(0, 1)) begin
            push_op(CMD_SEND);
            local_gap++;
          end else begin
            push_op(CMD_RECV);
            local_gap--;
          end
        end
        if ($urandom_range(0, 1)) begin
          while (local_gap > 0) begin
            push_op(CMD_RECV);
            local_gap--;
          end
          while (local_gap < 0) begin
            push_op(CMD_SEND);
            local_gap++;
          end
        end
      end
      for (int k = 0; k < kids; k++) begin
        if (!calm && $urandom_range(0, 3) == 0) begin
          d = $urandom_range(1, 5);
          kid_sent[k] += d;
          if ($urandom_range(0, 3) != 0) kid_recv[k] = kid_sent[k];
        end
        // now and then a response goes missing
        if ($urandom_range(0, 9) != 0) push_item(CMD_RESP, kid_sent[k], kid_recv[k]);
      end
      if ($urandom_range(0, 5) == 0) begin
        noise_op = CMD_W'($urandom_range(0, 7));
        if (!with_term && noise_op == CMD_TERM) noise_op = CMD_SEND;
        push_op(noise_op);
      end
    end
    if (with_term) push_op(CMD_TERM);
  endtask

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
      else idle++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    rst        = 1'b1;
    cfg_write  = 1'b0;
    cfg_index  = REG_NODE_RANK;
    cfg_data   = '0;
    in_valid   = 1'b0;
    command    = CMD_START;
    child_sent = '0;
    child_recv = '0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // single-rank root from reset: zero totals, wrap of the sums, reserved codes,
    // a response with nothing pending and a control arriving at the root
    push_op(CMD_START);
    push_op(CMD_SEND);
    push_op(CMD_RECV);
    push_op(CMD_START);
    push_op(CMD_RSVD_LO);
    push_op(CMD_RSVD_HI);
    push_item(CMD_RESP, '1, '1);
    push_op(CMD_CTRL);

    // highest rank with a clamped count: a leaf, start is ignored
    set_config(10'd1023, 11'd2047);
    push_op(CMD_CTRL);
    push_item(CMD_RESP, '0, '1);
    push_op(CMD_START);
    push_op(CMD_SEND);
    push_op(CMD_CTRL);

    // inner node with a full set of children
    set_config(10'd1, 11'd1024);
    push_op(CMD_CTRL);
    push_item(CMD_RESP, 64'h8000_0000_0000_0000, '0);
    push_item(CMD_RESP, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
    push_item(CMD_RESP, '1, 64'd1);
    push_item(CMD_RESP, '0, '0);
    push_op(CMD_RECV);

    run_phase(10'd255, 11'd1024, 12, 1'b0);  // three children at the edge of the tree
    run_phase(10'd300, 11'd3, 6, 1'b0);      // rank beyond the count, no children
    run_phase(10'd0, 11'd5, 20, 1'b0);
    run_phase(10'd0, 11'd0, 8, 1'b0);        // zero count behaves as one
    run_phase(10'd0, 11'd2, 10, 1'b0);
    run_phase(10'd0, 11'd2047, 14, 1'b1);
    run_phase(10'd1, 11'd1024, 12, 1'b1);
    run_phase(10'd1023, 11'd2047, 8, 1'b1);

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (12) @(negedge clk);
    $display("run covered %0d commands over %0d register settings after reset", items_live,
             settings_used);
    $display("%0d message beats compared, %0d of them local termination reports", beats,
             done_seen);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatching beats", errors);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
